FILE: src/button_press_duration_classifier_macros.svh
// Assertion macros for the button press duration classifier.
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPDC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bpdc_pkg.sv
`timescale 1ns / 1ps
package bpdc_pkg;

    localparam int unsigned THR_W   = 16;
    localparam int unsigned LIM_W   = 4;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT     = 1'b1;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd500;
    localparam logic [LIM_W-1:0] LIMIT_RST     = 4'd2;
    localparam logic [LIM_W-1:0] LIMIT_MIN     = 4'd1;
    localparam logic [CNT_W-1:0] CNT_MAX       = '1;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] now_ms;
        logic              clear_totals;
    } t_sample;

    typedef struct packed {
        logic [LIM_W-1:0]  integ;
        logic              confirmed;
        logic [TIME_W-1:0] press_start;
        logic              last_long;
        logic              green;
        logic              red;
        logic [CNT_W-1:0]  short_tally;
        logic [CNT_W-1:0]  long_tally;
        logic [TIME_W-1:0] short_sum;
        logic [TIME_W-1:0] long_sum;
    } t_state;

    typedef struct packed {
        logic              pressed_confirmed;
        logic              release_event;
        logic              press_was_long;
        logic [TIME_W-1:0] press_duration_ms;
        logic              short_led;
        logic              red_led;
        logic [CNT_W-1:0]  short_press_count;
        logic [CNT_W-1:0]  long_press_count;
        logic [TIME_W-1:0] short_duration_total;
        logic [TIME_W-1:0] long_duration_total;
    } t_result;

endpackage

FILE: src/button_press_duration_classifier.sv
`timescale 1ns / 1ps
// Button press duration classifier: debounces sampled button levels and
// classifies confirmed presses as short or long.
// Input channel (i_in_valid / o_in_ready): one sample per transfer, with the
// raw level, the millisecond timestamp and a request to clear the totals.
// Output channel (o_out_valid / i_out_ready): one result per sample, with the
// debounced state, release event, duration, LEDs, counts and totals.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0: long press threshold in ms, 1: debounce limit) at the clock edge.
// Result: registered in the output register, or in the skid register on a stall.
// Throughput: one sample per cycle unless stalled; the whole update is a single
// combinational pass from the state registers into the result register.
// Stall: a skid register holds one extra result, so one more sample is
// taken while a result waits; o_in_ready falls once the skid is full.
// Reset (synchronous, active low): state and counts clear, LEDs off,
// threshold returns to 500 ms and debounce limit to 2, output empty.
module button_press_duration_classifier
    import bpdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_button_level,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_clear_totals,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_pressed_confirmed,
    output logic                  o_release_event,
    output logic                  o_press_was_long,
    output logic [TIME_W-1:0]     o_press_duration_ms,
    output logic                  o_short_led,
    output logic                  o_red_led,
    output logic [CNT_W-1:0]      o_short_press_count,
    output logic [CNT_W-1:0]      o_long_press_count,
    output logic [TIME_W-1:0]     o_short_duration_total,
    output logic [TIME_W-1:0]     o_long_duration_total
);

    `include "button_press_duration_classifier_macros.svh"

    logic [THR_W-1:0] r_threshold;
    logic [LIM_W-1:0] r_limit;
    t_state           r_state;
    t_state           n_state;
    t_result          n_result;
    t_sample          sample;
    t_result          r_out;
    t_result          r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    logic             in_xfer;
    logic             out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_limit     <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_THRESHOLD: r_threshold <= i_cfg_wdata[THR_W-1:0];
                CFG_IDX_LIMIT:     r_limit     <= i_cfg_wdata[LIM_W-1:0];
            endcase
        end
    end

    assign sample.level        = i_button_level;
    assign sample.now_ms       = i_now_ms;
    assign sample.clear_totals = i_clear_totals;

    bpdc_step u_step (
        .i_state     (r_state),
        .i_sample    (sample),
        .i_threshold (r_threshold),
        .i_limit     (r_limit),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    assign o_in_ready = !r_skid_valid;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                // advance skid first, else take the new result
                r_out_valid  <= r_skid_valid || in_xfer;
                r_skid_valid <= 1'b0;
            end else if (in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_xfer) begin
                r_out <= n_result;
            end
        end
        if (in_xfer && !out_free) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_pressed_confirmed    = r_out.pressed_confirmed;
    assign o_release_event        = r_out.release_event;
    assign o_press_was_long       = r_out.press_was_long;
    assign o_press_duration_ms    = r_out.press_duration_ms;
    assign o_short_led            = r_out.short_led;
    assign o_red_led              = r_out.red_led;
    assign o_short_press_count    = r_out.short_press_count;
    assign o_long_press_count     = r_out.long_press_count;
    assign o_short_duration_total = r_out.short_duration_total;
    assign o_long_duration_total  = r_out.long_duration_total;

    `BPDC_ASSERT_IMPL(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `BPDC_ASSERT_NEXT(a_xfer_gives_result, in_xfer, r_out_valid, "transfer produced no result")
    `BPDC_ASSERT_IMPL(a_release_clears_press, r_out_valid && r_out.release_event, !r_out.pressed_confirmed, "release with press still confirmed")
    `BPDC_ASSERT_IMPL(a_leds_exclusive, r_out_valid, !(r_out.short_led && r_out.red_led), "both LEDs on")

endmodule

FILE: src/bpdc_step.sv
`timescale 1ns / 1ps
module bpdc_step
    import bpdc_pkg::*;
(
    input  t_state            i_state,
    input  t_sample           i_sample,
    input  logic [THR_W-1:0]  i_threshold,
    input  logic [LIM_W-1:0]  i_limit,
    output t_state            o_state,
    output t_result           o_result
);

    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  integ_n;
    logic [CNT_W-1:0]  short_base;
    logic [CNT_W-1:0]  long_base;
    logic [TIME_W-1:0] short_sum_base;
    logic [TIME_W-1:0] long_sum_base;
    logic              press_hit;
    logic              release_hit;
    logic [TIME_W-1:0] duration;
    logic              is_long;

    assign limit = (i_limit == '0) ? LIMIT_MIN : i_limit;

    always_comb begin
        if (i_sample.level) begin
            integ_n = (i_state.integ < limit) ? i_state.integ + LIM_W'(1) : i_state.integ;
        end else begin
            integ_n = (i_state.integ != '0) ? i_state.integ - LIM_W'(1) : i_state.integ;
        end
    end

    // clear the totals before this sample's release is counted
    assign short_base     = i_sample.clear_totals ? '0 : i_state.short_tally;
    assign long_base      = i_sample.clear_totals ? '0 : i_state.long_tally;
    assign short_sum_base = i_sample.clear_totals ? '0 : i_state.short_sum;
    assign long_sum_base  = i_sample.clear_totals ? '0 : i_state.long_sum;

    assign press_hit   = (integ_n >= limit) && !i_state.confirmed;
    assign release_hit = (integ_n == '0) && i_state.confirmed;
    assign duration    = i_sample.now_ms - i_state.press_start;
    assign is_long     = duration >= {{(TIME_W-THR_W){1'b0}}, i_threshold};

    always_comb begin
        o_state             = i_state;
        o_state.integ       = integ_n;
        o_state.short_tally = short_base;
        o_state.long_tally  = long_base;
        o_state.short_sum   = short_sum_base;
        o_state.long_sum    = long_sum_base;
        if (press_hit) begin
            o_state.confirmed   = 1'b1;
            o_state.press_start = i_sample.now_ms;
        end else if (release_hit) begin
            o_state.confirmed = 1'b0;
            o_state.last_long = is_long;
            o_state.green     = !is_long;
            o_state.red       = is_long;
            if (is_long) begin
                o_state.long_tally = (long_base != CNT_MAX) ? long_base + CNT_W'(1)
                                                            : long_base;
                o_state.long_sum   = long_sum_base + duration;
            end else begin
                o_state.short_tally = (short_base != CNT_MAX) ? short_base + CNT_W'(1)
                                                              : short_base;
                o_state.short_sum   = short_sum_base + duration;
            end
        end
    end

    always_comb begin
        o_result.pressed_confirmed    = o_state.confirmed;
        o_result.release_event        = release_hit;
        o_result.press_was_long       = o_state.last_long;
        o_result.press_duration_ms    = release_hit ? duration : '0;
        o_result.short_led            = o_state.green;
        o_result.red_led              = o_state.red;
        o_result.short_press_count    = o_state.short_tally;
        o_result.long_press_count     = o_state.long_tally;
        o_result.short_duration_total = o_state.short_sum;
        o_result.long_duration_total  = o_state.long_sum;
    end

endmodule

FILE: tb/button_press_duration_classifier_tb.sv
`timescale 1ns / 1ps
module button_press_duration_classifier_tb;
    import bpdc_pkg::*;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    localparam int IDLE_PCT        = 62;
    localparam int BOTH_IDLE_PCT   = 7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WRAP_PAIRS      = 30;
    localparam int PHASE_ITEMS     = 360;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_IDX_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_button_level = 1'b0;
    logic [TIME_W-1:0]     i_now_ms = '0;
    logic                  i_clear_totals = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_pressed_confirmed;
    logic                  o_release_event;
    logic                  o_press_was_long;
    logic [TIME_W-1:0]     o_press_duration_ms;
    logic                  o_short_led;
    logic                  o_red_led;
    logic [CNT_W-1:0]      o_short_press_count;
    logic [CNT_W-1:0]      o_long_press_count;
    logic [TIME_W-1:0]     o_short_duration_total;
    logic [TIME_W-1:0]     o_long_duration_total;

    button_press_duration_classifier DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_button_level         (i_button_level),
        .i_now_ms               (i_now_ms),
        .i_clear_totals         (i_clear_totals),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_pressed_confirmed    (o_pressed_confirmed),
        .o_release_event        (o_release_event),
        .o_press_was_long       (o_press_was_long),
        .o_press_duration_ms    (o_press_duration_ms),
        .o_short_led            (o_short_led),
        .o_red_led              (o_red_led),
        .o_short_press_count    (o_short_press_count),
        .o_long_press_count     (o_long_press_count),
        .o_short_duration_total (o_short_duration_total),
        .o_long_duration_total  (o_long_duration_total)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Classifier copy: configuration and debouncer/tally state
    logic [THR_W-1:0]  cfg_threshold = THRESHOLD_RST;
    logic [LIM_W-1:0]  cfg_limit     = LIMIT_RST;
    logic [LIM_W-1:0]  held_count    = '0;
    logic              held_state    = 1'b0;
    logic [TIME_W-1:0] press_t0      = '0;
    logic              prev_long     = 1'b0;
    logic              led_g         = 1'b0;
    logic              led_r         = 1'b0;
    logic [CNT_W-1:0]  n_short       = '0;
    logic [CNT_W-1:0]  n_long        = '0;
    logic [TIME_W-1:0] short_ms_sum  = '0;
    logic [TIME_W-1:0] long_ms_sum   = '0;

    t_result pending_results[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    logic    hold_off_req = 1'b0;
    logic    hold_seen = 1'b0;
    int      hold_left = 0;
    logic [TIME_W-1:0] tick_ms = '0;

    task automatic classify_sample(input logic level, input logic [TIME_W-1:0] now,
                                   input logic clr);
        t_result           r;
        logic [LIM_W-1:0]  eff;
        logic [TIME_W-1:0] dur;
        logic              rel;
        logic              lng;
        eff = (cfg_limit == '0) ? LIMIT_MIN : cfg_limit;
        rel = 1'b0;
        dur = '0;
        if (clr) begin
            n_short = '0;
            n_long = '0;
            short_ms_sum = '0;
            long_ms_sum = '0;
        end
        if (level) begin
            if (held_count < eff)
                held_count = held_count + LIM_W'(1);
        end else if (held_count != '0) begin
            held_count = held_count - LIM_W'(1);
        end
        if (held_count >= eff && !held_state) begin
            held_state = 1'b1;
            press_t0 = now;
        end else if (held_count == '0 && held_state) begin
            held_state = 1'b0;
            rel = 1'b1;
            dur = now - press_t0;
            lng = (dur >= {16'b0, cfg_threshold});
            if (lng) begin
                led_g = 1'b0;
                led_r = 1'b1;
                if (n_long != CNT_MAX)
                    n_long = n_long + CNT_W'(1);
                long_ms_sum = long_ms_sum + dur;
            end else begin
                led_g = 1'b1;
                led_r = 1'b0;
                if (n_short != CNT_MAX)
                    n_short = n_short + CNT_W'(1);
                short_ms_sum = short_ms_sum + dur;
            end
            prev_long = lng;
        end
        r.pressed_confirmed    = held_state;
        r.release_event        = rel;
        r.press_was_long       = prev_long;
        r.press_duration_ms    = dur;
        r.short_led            = led_g;
        r.red_led              = led_r;
        r.short_press_count    = n_short;
        r.long_press_count     = n_long;
        r.short_duration_total = short_ms_sum;
        r.long_duration_total  = long_ms_sum;
        pending_results.push_back(r);
    endtask

    task automatic send_sample(input logic level, input logic [TIME_W-1:0] now,
                               input logic clr);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_button_level <= level;
        i_now_ms <= now;
        i_clear_totals <= clr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        classify_sample(level, now, clr);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] lim_word);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_IDX_THRESHOLD;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_idx <= CFG_IDX_LIMIT;
        i_cfg_wdata <= lim_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_threshold = thr;
        cfg_limit = lim_word[LIM_W-1:0];
    endtask

    task automatic apply_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = IDLE_PCT;
                recv_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct <= IDLE_PCT;
            end
            default: begin
                send_idle_pct = BOTH_IDLE_PCT;
                recv_stall_pct <= BOTH_IDLE_PCT;
            end
        endcase
    endtask

    function automatic logic rand_clear();
        return ($urandom_range(99) < 4);
    endfunction

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_sample(1'($urandom_range(0, 1)), $urandom, rand_clear());
    endtask

    // One press with bounce; the releasing sample lands at a chosen duration
    task automatic drive_press();
        int                run;
        logic [TIME_W-1:0] target;
        logic [TIME_W-1:0] now;
        logic [LIM_W-1:0]  eff;
        logic              lvl;
        eff = (cfg_limit == '0) ? LIMIT_MIN : cfg_limit;
        case ($urandom_range(0, 4))
            0: target = {16'b0, cfg_threshold} - 1;
            1: target = {16'b0, cfg_threshold};
            2: target = {16'b0, cfg_threshold} + 1;
            3: target = $urandom_range(0, 2 * cfg_threshold + 2);
            default: target = $urandom;
        endcase
        run = eff + $urandom_range(0, 6);
        repeat (run) begin
            lvl = ($urandom_range(99) >= 10);
            tick_ms = tick_ms + $urandom_range(0, 3);
            send_sample(lvl, tick_ms, rand_clear());
        end
        while (held_state || held_count != '0) begin
            lvl = ($urandom_range(99) < 8);
            tick_ms = tick_ms + $urandom_range(0, 3);
            now = tick_ms;
            if (!lvl && held_state && held_count == 1)
                now = press_t0 + target;
            send_sample(lvl, now, rand_clear());
        end
    endtask

    task automatic test_reset_defaults();
        apply_idling(IDLE_NONE);
        send_sample(1'b1, 32'd0, 1'b0);
        send_sample(1'b0, 32'd1, 1'b0);
        send_sample(1'b1, 32'd10, 1'b0);
        send_sample(1'b1, 32'd20, 1'b0);
        send_sample(1'b1, 32'd25, 1'b0);
        send_sample(1'b0, 32'd300, 1'b0);
        send_sample(1'b0, 32'd519, 1'b0);
        send_sample(1'b1, 32'hFFFF_FF00, 1'b0);
        send_sample(1'b1, 32'hFFFF_FFFF, 1'b0);
        send_sample(1'b0, 32'h0000_01F0, 1'b1);
        send_sample(1'b0, 32'h0000_01F3, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_config_extremes();
        set_config(16'h0000, 16'h0000);
        send_sample(1'b1, 32'h8000_0000, 1'b0);
        send_sample(1'b0, 32'h8000_0000, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_limit_lowered();
        set_config(16'hFFFF, 16'h000F);
        send_sample(1'b1, 32'd10, 1'b0);
        send_sample(1'b1, 32'd20, 1'b0);
        send_sample(1'b1, 32'd30, 1'b0);
        send_sample(1'b1, 32'd40, 1'b0);
        wait_results_drained();
        set_config(16'hFFFF, 16'h0002);
        send_sample(1'b1, 32'd100, 1'b0);
        send_sample(1'b0, 32'd200, 1'b0);
        send_sample(1'b0, 32'd300, 1'b0);
        send_sample(1'b0, 32'd400, 1'b0);
        send_sample(1'b0, 32'd100 + 32'd65535, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_total_wrap();
        logic [TIME_W-1:0] t;
        apply_idling(IDLE_NONE);
        set_config(16'hFFFF, 16'h0001);
        repeat (WRAP_PAIRS) begin
            t = $urandom;
            send_sample(1'b1, t, 1'b0);
            send_sample(1'b0, t + 32'd65000 + $urandom_range(0, 534), 1'b0);
            t = $urandom;
            send_sample(1'b1, t, 1'b0);
            send_sample(1'b0, t + 32'd65535 + $urandom_range(0, 32'h7FFF_FFFF), 1'b0);
        end
        wait_results_drained();
    endtask

    task automatic test_input_stall();
        int start_count;
        apply_idling(IDLE_NONE);
        set_config(16'd20, 16'h0003);
        hold_off_req <= ~hold_off_req;
        start_count = items_sent;
        while (items_sent - start_count < 40)
            drive_press();
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        idle_mode_e        mode;
        int                goal;
        logic [THR_W-1:0]  thr;
        logic [LIM_W-1:0]  lim;
        for (int m = 0; m < 4; m++) begin
            mode = idle_mode_e'(m);
            case ($urandom_range(0, 4))
                0: thr = 16'd1;
                1: thr = 16'hFFFF;
                2: thr = 16'($urandom_range(0, 50));
                default: thr = 16'($urandom);
            endcase
            lim = (m == 0) ? 4'd15 : 4'($urandom_range(0, 15));
            set_config(thr, {12'($urandom), lim});
            apply_idling(mode);
            tick_ms = $urandom;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(99) < 15)
                    send_noise();
                else
                    drive_press();
            end
            wait_results_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_off_req != hold_seen) begin
            hold_seen <= hold_off_req;
            hold_left <= HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t result expected none actual duration %0h", $time,
                         o_press_duration_ms);
            end else begin
                want = pending_results.pop_front();
                compare_field("pressed_confirmed", 32'(want.pressed_confirmed),
                              32'(o_pressed_confirmed));
                compare_field("release_event", 32'(want.release_event),
                              32'(o_release_event));
                compare_field("press_was_long", 32'(want.press_was_long),
                              32'(o_press_was_long));
                compare_field("press_duration_ms", want.press_duration_ms,
                              o_press_duration_ms);
                compare_field("short_led", 32'(want.short_led), 32'(o_short_led));
                compare_field("red_led", 32'(want.red_led), 32'(o_red_led));
                compare_field("short_press_count", 32'(want.short_press_count),
                              32'(o_short_press_count));
                compare_field("long_press_count", 32'(want.long_press_count),
                              32'(o_long_press_count));
                compare_field("short_duration_total", want.short_duration_total,
                              o_short_duration_total);
                compare_field("long_duration_total", want.long_duration_total,
                              o_long_duration_total);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_config_extremes();
        test_limit_lowered();
        test_total_wrap();
        test_input_stall();
        test_random_traffic();
        repeat (5) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t results expected %0d more actual 0", $time,
                     pending_results.size());
        end
        if (mismatches == 0)
            $display("PASS button_press_duration_classifier");
        else
            $display("FAIL button_press_duration_classifier");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL button_press_duration_classifier");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/bpdc_pkg.sv
src/bpdc_step.sv
src/button_press_duration_classifier.sv
tb/button_press_duration_classifier_tb.sv
